// ----- sv/pms_pkg.sv -----
// Package for the protocol marker scanner: mode codes, marker texts and helpers.
package pms_pkg;

   localparam int HIST_DEPTH  = 14;
   localparam int NUM_PFX     = 7;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int MIN_LENGTH  = 8;

   typedef enum logic [2:0] {
      MODE_NONE = 3'd0,
      MODE_FTP  = 3'd1,
      MODE_SMTP = 3'd2,
      MODE_RTSP = 3'd3,
      MODE_WEB  = 3'd4
   } mode_type;

   typedef enum logic {
      REG_MODE  = 1'b0,
      REG_SPARE = 1'b1
   } reg_index_type;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_BSL   = 8'h5C;

   // Substring markers; the final character sits in the low byte.
   localparam logic [8*15-1:0] PAT_CONTENT = "Content-Length:";
   localparam logic [8*9-1:0]  PAT_RCPT    = "RCPT TO:<";
   localparam logic [8*8-1:0]  PAT_SESSION = "Session:";
   localparam logic [8*5-1:0]  PAT_AUTH    = "AUTH ";

   // Line prefixes, padded to eight columns. First three complete a marker directly.
   localparam logic [7:0] PFX_TEXT [NUM_PFX][8] = '{
      '{"R", "N", "T", "O", " ", 8'h00, 8'h00, 8'h00},
      '{"M", "L", "S", "D", " ", 8'h00, 8'h00, 8'h00},
      '{"M", "L", "S", "T", " ", 8'h00, 8'h00, 8'h00},
      '{"R", "N", "F", "R", " ", 8'h00, 8'h00, 8'h00},
      '{"M", "K", "D", " ", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"X", "M", "K", "D", " ", 8'h00, 8'h00, 8'h00},
      '{"C", "W", "D", " ", 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [2:0] PFX_LEN [NUM_PFX] = '{3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd5, 3'd4};
   localparam logic [NUM_PFX-1:0] DIRECT_PFX = 7'b000_0111;

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= "a" && c <= "z") begin
         r = c - 8'd32;
      end
      return r;
   endfunction

endpackage

// ----- sv/protocol_marker_scanner.sv -----
// Top level of the protocol marker scanner: byte scan, marker compare and result register.
//
// Takes one buffer word per cycle and gives one marker_found word on each
// final byte, in the cycle after that byte is accepted. All compares run
// over a fourteen-byte history register and the current byte in the accept
// cycle, so the sustained rate is one byte per clock. The input stalls only
// when a final byte arrives while the previous result is still held by a
// stalled output. protocol_mode lives at byte address 0 of the register port.
module protocol_marker_scanner (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_marker_found,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pms_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pms_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pms_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);
   import pms_pkg::*;

   mode_type                    mode_ff, mode_in;
   logic [8*HIST_DEPTH-1:0]     hist_ff, hist_in;
   logic [2:0]                  col_ff, col_in;
   logic [NUM_PFX-1:0]          alive_ff, alive_in;
   logic                        armed_ff, armed_in;
   logic                        seen_ff, seen_in;
   logic [3:0]                  count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        found_ff, found_in;

   logic                        accept;
   logic                        csr_write;
   reg_index_type               csr_index;
   logic [8*(HIST_DEPTH+1)-1:0] window;
   logic [7:0]                  up;
   logic                        direct_done, arm_done, quote_hit, auth_done, hit;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_index == REG_MODE) ? {{(CSR_DATA_W-3){1'b0}}, mode_ff}
                                               : '0;

   assign req_stall        = rsp_valid_ff && rsp_stall && req_last_byte;
   assign accept           = req_valid && !req_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_marker_found = found_ff;

   assign window = {hist_ff, req_data_byte};
   assign up     = to_upper(req_data_byte);

   always_comb begin
      mode_in = mode_ff;
      if (csr_write && csr_index == REG_MODE) begin
         mode_in = mode_type'(csr_pwdata[2:0]);
      end
   end

   // FTP line prefixes
   always_comb begin
      alive_in    = alive_ff;
      direct_done = 1'b0;
      arm_done    = 1'b0;
      for (int p = 0; p < NUM_PFX; p++) begin
         if (alive_ff[p] && col_ff < PFX_LEN[p]) begin
            if (up != PFX_TEXT[p][col_ff]) begin
               alive_in[p] = 1'b0;
            end else if (col_ff == PFX_LEN[p] - 3'd1) begin
               if (DIRECT_PFX[p]) begin
                  direct_done = 1'b1;
               end else begin
                  arm_done = 1'b1;
               end
            end
         end
      end
      if (req_data_byte == CHAR_LF) begin
         alive_in = '1;
      end
   end

   always_comb begin
      quote_hit = armed_ff && (req_data_byte == CHAR_QUOTE || req_data_byte == CHAR_BSL);
      armed_in  = armed_ff;
      if (req_data_byte == CHAR_CR || req_data_byte == CHAR_LF) begin
         armed_in = 1'b0;
      end
      if (arm_done) begin
         armed_in = 1'b1;
      end
   end

   always_comb begin
      auth_done = (col_ff == 3'd4);
      for (int k = 0; k < 5; k++) begin
         if (to_upper(window[8*k +: 8]) != PAT_AUTH[8*k +: 8]) begin
            auth_done = 1'b0;
         end
      end
   end

   always_comb begin
      case (mode_ff)
         MODE_FTP:  hit = direct_done || quote_hit;
         MODE_SMTP: hit = auth_done || (window[8*9-1:0] == PAT_RCPT);
         MODE_RTSP: hit = (window[8*8-1:0] == PAT_SESSION);
         MODE_WEB:  hit = (window[8*15-1:0] == PAT_CONTENT);
         default:   hit = 1'b0;
      endcase
   end

   always_comb begin
      count_in = (count_ff == 4'd15) ? count_ff : count_ff + 4'd1;
      seen_in  = seen_ff || hit;
      if (req_data_byte == CHAR_LF) begin
         col_in = '0;
      end else if (col_ff < 3'd7) begin
         col_in = col_ff + 3'd1;
      end else begin
         col_in = col_ff;
      end
      hist_in  = {hist_ff[8*(HIST_DEPTH-1)-1:0], req_data_byte};
      found_in = seen_in && (count_in >= 4'(MIN_LENGTH));
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && req_last_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NONE;
         hist_ff      <= '0;
         col_ff       <= '0;
         alive_ff     <= '1;
         armed_ff     <= 1'b0;
         seen_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_last_byte) begin
               hist_ff  <= '0;
               col_ff   <= '0;
               alive_ff <= '1;
               armed_ff <= 1'b0;
               seen_ff  <= 1'b0;
               count_ff <= '0;
            end else begin
               hist_ff  <= hist_in;
               col_ff   <= col_in;
               alive_ff <= alive_in;
               armed_ff <= armed_in;
               seen_ff  <= seen_in;
               count_ff <= count_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last_byte) begin
         found_ff <= found_in;
      end
   end

endmodule

// ----- sv/pms_checker.sv -----
// Port-level checker for the protocol marker scanner, bound to the top level.
module pms_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_last_byte,
   input logic rsp_valid,
   input logic rsp_stall
);

   logic accept;
   assign accept = req_valid && !req_stall;

   // held result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(accept && req_last_byte))
      else $error("result word without a final byte");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> rsp_valid)
      else $error("final byte gave no result word");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      accept && !req_last_byte && !(rsp_valid && rsp_stall) |=> !rsp_valid)
      else $error("result word from a non-final byte");

endmodule

bind protocol_marker_scanner pms_checker u_pms_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_last_byte (req_last_byte),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall)
);
